### rtl/axis_command_interlock_unit_assert.svh
// Assertion macros for the axis command interlock unit.
// Depends on nothing; included by the top level, the one module that carries checks.
`ifndef AXIS_COMMAND_INTERLOCK_UNIT_ASSERT_SVH
`define AXIS_COMMAND_INTERLOCK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ACI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ACI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ACI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/aci_pkg.sv
// Shared types, codes and reset constants for the axis command interlock unit.
// Depends on nothing; imported by every module of the block.
package aci_pkg;

    localparam int AXES    = 3;
    localparam int POS_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef enum logic [2:0] {
        OP_SERVO_ON    = 3'd0,
        OP_SERVO_OFF   = 3'd1,
        OP_HOME        = 3'd2,
        OP_MOVE_ABS    = 3'd3,
        OP_MOVE_REL    = 3'd4,
        OP_STOP        = 3'd5,
        OP_RESET_ALARM = 3'd6,
        OP_QUERY       = 3'd7
    } aci_opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SERVO_OFF = 3'd1,
        ST_HOME_REQ  = 3'd2,
        ST_LIMIT     = 3'd3,
        ST_BAD_AXIS  = 3'd4,
        ST_IN_ALARM  = 3'd5,
        ST_NOT_ALARM = 3'd6
    } aci_status_t;

    typedef enum logic [2:0] {
        MODE_SERVO_OFF = 3'd0,
        MODE_READY     = 3'd1,
        MODE_HOMING    = 3'd2,
        MODE_MOVING    = 3'd3,
        MODE_INPOS     = 3'd4,
        MODE_ALARM     = 3'd5
    } aci_mode_t;

    localparam logic [1:0] AXIS_X       = 2'd0;
    localparam logic [1:0] AXIS_Y       = 2'd1;
    localparam logic [1:0] AXIS_Z       = 2'd2;
    localparam logic [1:0] AXIS_INVALID = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Z_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Z_MAX = 3'd5;

    // 500.0 and 300.0 units at 8 fraction bits
    localparam logic signed [POS_W-1:0] XY_MAX_RST = 32'sd128000;
    localparam logic signed [POS_W-1:0] Z_MAX_RST  = 32'sd76800;
    localparam logic signed [POS_W-1:0] MIN_RST    = 32'sd0;

    typedef struct packed {
        aci_opcode_t             opcode;
        logic [1:0]              axis_sel;
        logic signed [POS_W-1:0] move_value;
    } aci_cmd_t;

    typedef struct packed {
        aci_status_t             status;
        aci_mode_t               axis_mode;
        logic signed [POS_W-1:0] current_pos;
        logic signed [POS_W-1:0] target_pos;
        logic                    servo_enabled;
        logic                    home_done;
        logic                    has_moved;
        logic                    any_alarm;
    } aci_res_t;

    typedef struct packed {
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
    } aci_limit_t;

endpackage

### rtl/aci_limit_regs.sv
// Position limit registers of the axis command interlock unit.
// Depends on aci_pkg.
module aci_limit_regs
    import aci_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [REG_IDX_W-1:0]    cfg_index,
    input  logic [POS_W-1:0]        cfg_data,
    output aci_limit_t [AXES-1:0]   limits
);

    aci_limit_t [AXES-1:0] limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg[0] <= '{lo: MIN_RST, hi: XY_MAX_RST};
            limits_reg[1] <= '{lo: MIN_RST, hi: XY_MAX_RST};
            limits_reg[2] <= '{lo: MIN_RST, hi: Z_MAX_RST};
        end
        else if (cfg_wr_en)
        begin
            // drop writes beyond the last register
            case (cfg_index)
                REG_X_MIN: limits_reg[0].lo <= cfg_data;
                REG_X_MAX: limits_reg[0].hi <= cfg_data;
                REG_Y_MIN: limits_reg[1].lo <= cfg_data;
                REG_Y_MAX: limits_reg[1].hi <= cfg_data;
                REG_Z_MIN: limits_reg[2].lo <= cfg_data;
                REG_Z_MAX: limits_reg[2].hi <= cfg_data;
                default: ;
            endcase
        end
    end

    assign limits = limits_reg;

endmodule

### rtl/aci_axis_core.sv
// Axis state and single-pass interlock evaluation for one command.
// Depends on aci_pkg.
module aci_axis_core
    import aci_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  aci_cmd_t                cmd,
    input  aci_limit_t [AXES-1:0]   limits,
    output aci_res_t                res_next
);

    aci_mode_t               mode_reg    [AXES];
    logic signed [POS_W-1:0] current_reg [AXES];
    logic signed [POS_W-1:0] target_reg  [AXES];
    logic                    servo_reg   [AXES];
    logic                    homed_reg   [AXES];
    logic                    moving_reg  [AXES];

    logic                    bad_axis;
    logic [1:0]              rd_idx;
    logic                    write_en;
    aci_status_t             st;
    aci_mode_t               mode_next;
    logic signed [POS_W-1:0] current_next;
    logic signed [POS_W-1:0] target_next;
    logic                    servo_next;
    logic                    homed_next;
    logic                    moving_next;
    logic                    alarm;
    logic signed [POS_W:0]   new_pos;
    logic signed [POS_W:0]   lim_lo;
    logic signed [POS_W:0]   lim_hi;
    logic                    pos_in_limits;
    logic                    any_alarm;

    assign bad_axis = (cmd.axis_sel == AXIS_INVALID);
    assign rd_idx   = bad_axis ? AXIS_X : cmd.axis_sel;
    assign write_en = cmd_valid && !bad_axis;
    assign alarm    = (mode_reg[rd_idx] == MODE_ALARM);

    // 33-bit position so a relative move cannot wrap
    always_comb
    begin
        if (cmd.opcode == OP_MOVE_ABS)
            new_pos = {cmd.move_value[POS_W-1], cmd.move_value};
        else
            new_pos = {current_reg[rd_idx][POS_W-1], current_reg[rd_idx]}
                    + {cmd.move_value[POS_W-1], cmd.move_value};
        lim_lo = {limits[rd_idx].lo[POS_W-1], limits[rd_idx].lo};
        lim_hi = {limits[rd_idx].hi[POS_W-1], limits[rd_idx].hi};
        pos_in_limits = (new_pos >= lim_lo) && (new_pos <= lim_hi);
    end

    always_comb
    begin
        st           = ST_OK;
        mode_next    = mode_reg[rd_idx];
        current_next = current_reg[rd_idx];
        target_next  = target_reg[rd_idx];
        servo_next   = servo_reg[rd_idx];
        homed_next   = homed_reg[rd_idx];
        moving_next  = moving_reg[rd_idx];
        if (bad_axis)
        begin
            st = ST_BAD_AXIS;
        end
        else
        begin
            case (cmd.opcode)
                OP_SERVO_ON:
                begin
                    if (alarm)
                        st = ST_IN_ALARM;
                    else
                    begin
                        servo_next = 1'b1;
                        mode_next  = MODE_READY;
                    end
                end
                OP_SERVO_OFF:
                begin
                    servo_next  = 1'b0;
                    moving_next = 1'b0;
                    mode_next   = MODE_SERVO_OFF;
                end
                OP_HOME:
                begin
                    if (alarm)
                        st = ST_IN_ALARM;
                    else if (!servo_reg[rd_idx])
                        st = ST_SERVO_OFF;
                    else
                    begin
                        current_next = '0;
                        target_next  = '0;
                        moving_next  = 1'b1;
                        homed_next   = 1'b1;
                        mode_next    = MODE_INPOS;
                    end
                end
                OP_MOVE_ABS, OP_MOVE_REL:
                begin
                    if (alarm)
                        st = ST_IN_ALARM;
                    else if (!servo_reg[rd_idx])
                        st = ST_SERVO_OFF;
                    else if (!homed_reg[rd_idx])
                        st = ST_HOME_REQ;
                    else if (!pos_in_limits)
                    begin
                        st        = ST_LIMIT;
                        mode_next = MODE_ALARM;
                    end
                    else
                    begin
                        current_next = new_pos[POS_W-1:0];
                        target_next  = new_pos[POS_W-1:0];
                        moving_next  = 1'b1;
                        mode_next    = MODE_INPOS;
                    end
                end
                OP_STOP:
                begin
                    if (alarm)
                        st = ST_IN_ALARM;
                    else
                    begin
                        moving_next = 1'b0;
                        mode_next   = servo_reg[rd_idx] ? MODE_READY : MODE_SERVO_OFF;
                    end
                end
                OP_RESET_ALARM:
                begin
                    if (!alarm)
                        st = ST_NOT_ALARM;
                    else
                    begin
                        moving_next = 1'b0;
                        servo_next  = 1'b0;
                        homed_next  = 1'b0;
                        mode_next   = MODE_SERVO_OFF;
                    end
                end
                default: ;
            endcase
        end
    end

    // alarm summary over the state as it stands after this command
    always_comb
    begin
        any_alarm = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            if (!bad_axis && (cmd.axis_sel == i[1:0]))
                any_alarm = any_alarm || (mode_next == MODE_ALARM);
            else
                any_alarm = any_alarm || (mode_reg[i] == MODE_ALARM);
        end
    end

    always_comb
    begin
        res_next.status    = st;
        res_next.any_alarm = any_alarm;
        if (bad_axis)
        begin
            res_next.axis_mode     = MODE_SERVO_OFF;
            res_next.current_pos   = '0;
            res_next.target_pos    = '0;
            res_next.servo_enabled = 1'b0;
            res_next.home_done     = 1'b0;
            res_next.has_moved     = 1'b0;
        end
        else
        begin
            res_next.axis_mode     = mode_next;
            res_next.current_pos   = current_next;
            res_next.target_pos    = target_next;
            res_next.servo_enabled = servo_next;
            res_next.home_done     = homed_next;
            res_next.has_moved     = moving_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                mode_reg[i]    <= MODE_SERVO_OFF;
                current_reg[i] <= '0;
                target_reg[i]  <= '0;
                servo_reg[i]   <= 1'b0;
                homed_reg[i]   <= 1'b0;
                moving_reg[i]  <= 1'b0;
            end
        end
        else if (write_en)
        begin
            mode_reg[rd_idx]    <= mode_next;
            current_reg[rd_idx] <= current_next;
            target_reg[rd_idx]  <= target_next;
            servo_reg[rd_idx]   <= servo_next;
            homed_reg[rd_idx]   <= homed_next;
            moving_reg[rd_idx]  <= moving_next;
        end
    end

endmodule

### rtl/axis_command_interlock_unit.sv
// Axis command interlock unit: top level with command and result registers.
// Depends on aci_pkg, aci_limit_regs, aci_axis_core and the assertion header.
//
// Command interlock for three motion axes (x, y, z). Present a command on cmd
// and raise start; busy is never raised, so a transfer happens at every edge
// with start high and one command may follow another in each cycle. The
// command is registered, checked against the addressed axis in one pass
// (bad axis, alarm, servo, homed, position limits) and its result lands in
// the result register: done is high for exactly one cycle once the command
// has passed the command register and then the result register, with result
// holding the status, the axis fields after the command and the any-alarm
// flag. The receiver cannot stall, so capture result whenever done is high.
// Throughput is one command per cycle, with the command register and the
// result register around a single 33-bit add and limit compare. Back-to-back
// commands see each other's effect, because axis state updates on the same
// edge that loads the result. Limits are written through cfg_wr_en,
// cfg_index and cfg_data; write them only while no command is in flight.
// Indexes beyond the z maximum are ignored.
`include "axis_command_interlock_unit_assert.svh"

module axis_command_interlock_unit
    import aci_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  aci_cmd_t                cmd,
    input  logic                    cfg_wr_en,
    input  logic [REG_IDX_W-1:0]    cfg_index,
    input  logic [POS_W-1:0]        cfg_data,
    output logic                    done,
    output aci_res_t                result
);

    aci_limit_t [AXES-1:0] limits;
    aci_cmd_t              cmd_reg;
    logic                  cmd_valid_reg;
    aci_res_t              res_next;
    aci_res_t              res_reg;
    logic                  done_reg;

    // Every cycle takes a new command; nothing holds the front end.
    assign busy = 1'b0;

    // Hold the command transfer for the evaluation cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
    end

    aci_limit_regs u_limits (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    aci_axis_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid_reg),
        .cmd       (cmd_reg),
        .limits    (limits),
        .res_next  (res_next)
    );

    // Advance the evaluated result into the output register; done lasts one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    `ACI_ASSERT_NXT(a_cmd_taken, clk, rst_n, start, cmd_valid_reg, "command transfer lost")
    `ACI_ASSERT_NXT(a_done_follows, clk, rst_n, cmd_valid_reg, done_reg, "result not delivered")
    `ACI_ASSERT_NXT(a_no_spurious, clk, rst_n, !cmd_valid_reg, !done_reg, "result without command")
    `ACI_ASSERT_IMP(a_limit_alarm, clk, rst_n, done_reg && (res_reg.status == ST_LIMIT), (res_reg.axis_mode == MODE_ALARM) && res_reg.any_alarm, "limit fault without alarm")
    `ACI_ASSERT_IMP(a_bad_axis_zero, clk, rst_n, done_reg && (res_reg.status == ST_BAD_AXIS), (res_reg.axis_mode == MODE_SERVO_OFF) && !res_reg.servo_enabled && !res_reg.home_done && !res_reg.has_moved, "bad axis fields not cleared")

endmodule
